### hw/rtl/kth_largest_stream_tracker_defines.svh
// Assertion macros used by the kth-largest tracker datapath (kls_dp).
`ifndef KTH_LARGEST_STREAM_TRACKER_DEFINES_SVH
`define KTH_LARGEST_STREAM_TRACKER_DEFINES_SVH

// Same-cycle implication on clk, disabled while rst_n is low.
`define KLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kls check failed");

// Next-cycle implication on clk, disabled while rst_n is low.
`define KLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kls check failed");

`endif

### hw/rtl/kls_pkg.sv
// Package: sizes, microcode encoding and control program of the kth-largest tracker.
`timescale 1ns / 1ps
package kls_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;
    localparam int STEP_W   = 4;
    localparam int OUT_W    = ((DATA_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_POS_ZERO,
        OP_READ_LEFT,
        OP_CMP_LEFT,
        OP_CMP_RIGHT,
        OP_WRITE_BEST,
        OP_WRITE_VAL,
        OP_GROW,
        OP_READ_PARENT,
        OP_WRITE_PARENT,
        OP_LOAD_OUT
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_FIRE,
        C_GROW,
        C_REPLACE,
        C_NO_LEFT,
        C_NO_RIGHT,
        C_BEST_MOVED,
        C_AT_ROOT,
        C_PARENT_LE,
        C_PRE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic                in_rdy;
        op_t                 op;
        cond_t               cond;
        logic                neg;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic fire;
        logic grow;
        logic replace;
        logic no_left;
        logic no_right;
        logic best_moved;
        logic at_root;
        logic parent_le;
        logic pre;
        logic out_busy;
    } flags_t;

    // Program step labels
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] S_CHECK    = 4'd2;
    localparam logic [STEP_W-1:0] S_DN_LEFT  = 4'd3;
    localparam logic [STEP_W-1:0] S_DN_CMPL  = 4'd4;
    localparam logic [STEP_W-1:0] S_DN_CMPR  = 4'd5;
    localparam logic [STEP_W-1:0] S_DN_MOVE  = 4'd6;
    localparam logic [STEP_W-1:0] S_DN_EXIT  = 4'd7;
    localparam logic [STEP_W-1:0] S_DN_LEAF  = 4'd8;
    localparam logic [STEP_W-1:0] S_UP_INIT  = 4'd9;
    localparam logic [STEP_W-1:0] S_UP_READ  = 4'd10;
    localparam logic [STEP_W-1:0] S_UP_CMP   = 4'd11;
    localparam logic [STEP_W-1:0] S_UP_MOVE  = 4'd12;
    localparam logic [STEP_W-1:0] S_UP_DONE  = 4'd13;
    localparam logic [STEP_W-1:0] S_FINISH   = 4'd14;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd15;

    // Control store: one word per step; jump to target when cond (xor neg) holds.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c.in_rdy = 1'b0;
        c.op     = OP_NONE;
        c.cond   = C_ALWAYS;
        c.neg    = 1'b1;
        c.target = S_IDLE;
        case (step)
            S_IDLE:
            begin
                c.in_rdy = 1'b1;
                c.op     = OP_LATCH;
                c.cond   = C_FIRE;
                c.target = S_IDLE;
            end
            S_DISPATCH:
            begin
                c.cond   = C_GROW;
                c.neg    = 1'b0;
                c.target = S_UP_INIT;
            end
            S_CHECK:
            begin
                c.op     = OP_POS_ZERO;
                c.cond   = C_REPLACE;
                c.target = S_FINISH;
            end
            S_DN_LEFT:
            begin
                c.op     = OP_READ_LEFT;
                c.cond   = C_NO_LEFT;
                c.neg    = 1'b0;
                c.target = S_DN_LEAF;
            end
            S_DN_CMPL:
            begin
                c.op     = OP_CMP_LEFT;
                c.cond   = C_NO_RIGHT;
                c.neg    = 1'b0;
                c.target = S_DN_MOVE;
            end
            S_DN_CMPR:
            begin
                c.op = OP_CMP_RIGHT;
            end
            S_DN_MOVE:
            begin
                c.op     = OP_WRITE_BEST;
                c.cond   = C_BEST_MOVED;
                c.neg    = 1'b0;
                c.target = S_DN_LEFT;
            end
            S_DN_EXIT:
            begin
                c.neg    = 1'b0;
                c.target = S_FINISH;
            end
            S_DN_LEAF:
            begin
                c.op     = OP_WRITE_VAL;
                c.neg    = 1'b0;
                c.target = S_FINISH;
            end
            S_UP_INIT:
            begin
                c.op = OP_GROW;
            end
            S_UP_READ:
            begin
                c.op     = OP_READ_PARENT;
                c.cond   = C_AT_ROOT;
                c.neg    = 1'b0;
                c.target = S_UP_DONE;
            end
            S_UP_CMP:
            begin
                c.cond   = C_PARENT_LE;
                c.neg    = 1'b0;
                c.target = S_UP_DONE;
            end
            S_UP_MOVE:
            begin
                c.op     = OP_WRITE_PARENT;
                c.neg    = 1'b0;
                c.target = S_UP_READ;
            end
            S_UP_DONE:
            begin
                c.op = OP_WRITE_VAL;
            end
            S_FINISH:
            begin
                c.cond   = C_PRE;
                c.neg    = 1'b0;
                c.target = S_IDLE;
            end
            S_EMIT:
            begin
                c.op     = OP_LOAD_OUT;
                c.cond   = C_OUT_BUSY;
                c.neg    = 1'b0;
                c.target = S_EMIT;
            end
            default:
            begin
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/kls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/kls_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module kls_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  kls_pkg::flags_t flags,
    output kls_pkg::ctrl_t  ctrl
);

    logic [kls_pkg::STEP_W-1:0] step_reg;
    logic [kls_pkg::STEP_W-1:0] step_next;
    logic                       cond_hit;

    assign ctrl = kls_pkg::ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            kls_pkg::C_ALWAYS:     cond_hit = 1'b1;
            kls_pkg::C_FIRE:       cond_hit = flags.fire;
            kls_pkg::C_GROW:       cond_hit = flags.grow;
            kls_pkg::C_REPLACE:    cond_hit = flags.replace;
            kls_pkg::C_NO_LEFT:    cond_hit = flags.no_left;
            kls_pkg::C_NO_RIGHT:   cond_hit = flags.no_right;
            kls_pkg::C_BEST_MOVED: cond_hit = flags.best_moved;
            kls_pkg::C_AT_ROOT:    cond_hit = flags.at_root;
            kls_pkg::C_PARENT_LE:  cond_hit = flags.parent_le;
            kls_pkg::C_PRE:        cond_hit = flags.pre;
            kls_pkg::C_OUT_BUSY:   cond_hit = flags.out_busy;
            default:               cond_hit = 1'b0;
        endcase
        // Jump when the hit xor neg holds, otherwise advance (wrapping after the last step)
        if (cond_hit ^ ctrl.neg)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + kls_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= kls_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### hw/rtl/kls_dp.sv
// Datapath: heap memory, sift registers, k register, result register and flags.
`timescale 1ns / 1ps
`include "kth_largest_stream_tracker_defines.svh"
module kls_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kls_pkg::ctrl_t                ctrl,
    output kls_pkg::flags_t               flags,
    input  logic                          in_valid,
    input  logic signed [kls_pkg::DATA_W-1:0] in_value,
    input  logic                          in_pre,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kls_pkg::CNT_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kls_pkg::DATA_W-1:0]    out_kth,
    output logic [kls_pkg::CNT_W-1:0]     out_held
);

    localparam int AW = kls_pkg::ADDR_W;
    localparam int CW = kls_pkg::CNT_W;
    localparam int IW = kls_pkg::IDX_W;
    localparam int DW = kls_pkg::DATA_W;

    // Control state
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic          out_valid_reg, out_valid_next;

    // Payload
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] best_reg, best_next;
    logic signed [DW-1:0] root_reg, root_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        bpos_reg, bpos_next;
    logic                 pre_reg, pre_next;
    logic [DW-1:0]        kth_reg, kth_next;
    logic [CW-1:0]        held_reg, held_next;

    logic [CW-1:0]        k_eff;
    logic [IW-1:0]        lc, rc;
    logic [AW-1:0]        parent;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DW-1:0]        mem_wdata, mem_rdata;
    logic signed [DW-1:0] rd_s;
    logic                 fire, out_busy;

    kls_ram #(
        .WIDTH (DW),
        .DEPTH (kls_pkg::CAPACITY)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pos_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_ready = 1'b1;
    assign rd_s      = $signed(mem_rdata);
    assign lc        = {1'b0, pos_reg, 1'b1};
    assign rc        = lc + IW'(1);
    assign parent    = AW'((pos_reg - AW'(1)) >> 1);
    assign fire      = in_valid && ctrl.in_rdy;
    assign out_busy  = out_valid_reg && !out_ready;

    // k of zero counts as one, k beyond the heap saturates
    always_comb
    begin
        if (kept_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (kept_reg > CW'(kls_pkg::CAPACITY))
        begin
            k_eff = CW'(kls_pkg::CAPACITY);
        end
        else
        begin
            k_eff = kept_reg;
        end
    end

    always_comb
    begin
        flags.fire       = fire;
        flags.grow       = size_reg < k_eff;
        flags.replace    = (size_reg != '0) && (val_reg > root_reg);
        flags.no_left    = lc >= IW'(size_reg);
        flags.no_right   = rc >= IW'(size_reg);
        flags.best_moved = bpos_reg != pos_reg;
        flags.at_root    = pos_reg == '0;
        flags.parent_le  = rd_s <= val_reg;
        flags.pre        = pre_reg;
        flags.out_busy   = out_busy;
    end

    always_comb
    begin
        size_next      = size_reg;
        kept_next      = kept_reg;
        out_valid_next = out_valid_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        pos_next       = pos_reg;
        bpos_next      = bpos_reg;
        pre_next       = pre_reg;
        kth_next       = kth_reg;
        held_next      = held_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = lc[AW-1:0];
        mem_wdata      = val_reg;

        if (cfg_valid)
        begin
            kept_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.op)
            kls_pkg::OP_LATCH:
            begin
                if (fire)
                begin
                    val_next = in_value;
                    pre_next = in_pre;
                end
            end
            kls_pkg::OP_POS_ZERO:
            begin
                pos_next = '0;
            end
            kls_pkg::OP_READ_LEFT:
            begin
                // Start a level: the moving value is the candidate minimum
                mem_re    = 1'b1;
                mem_raddr = lc[AW-1:0];
                best_next = val_reg;
                bpos_next = pos_reg;
            end
            kls_pkg::OP_CMP_LEFT:
            begin
                mem_re    = 1'b1;
                mem_raddr = rc[AW-1:0];
                if (rd_s < best_reg)
                begin
                    best_next = rd_s;
                    bpos_next = lc[AW-1:0];
                end
            end
            kls_pkg::OP_CMP_RIGHT:
            begin
                if (rd_s < best_reg)
                begin
                    best_next = rd_s;
                    bpos_next = rc[AW-1:0];
                end
            end
            kls_pkg::OP_WRITE_BEST:
            begin
                // Move the smaller child up into the hole, or settle the value
                mem_we    = 1'b1;
                mem_wdata = best_reg;
                pos_next  = bpos_reg;
            end
            kls_pkg::OP_WRITE_VAL:
            begin
                mem_we    = 1'b1;
                mem_wdata = val_reg;
            end
            kls_pkg::OP_GROW:
            begin
                pos_next  = size_reg[AW-1:0];
                size_next = size_reg + CW'(1);
            end
            kls_pkg::OP_READ_PARENT:
            begin
                mem_re    = 1'b1;
                mem_raddr = parent;
            end
            kls_pkg::OP_WRITE_PARENT:
            begin
                // Pull the larger parent down into the hole
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                pos_next  = parent;
            end
            kls_pkg::OP_LOAD_OUT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    kth_next       = root_reg;
                    held_next      = size_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Track the root so the replace test and the result need no read
    always_comb
    begin
        root_next = root_reg;
        if (mem_we && (pos_reg == '0))
        begin
            root_next = $signed(mem_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            kept_reg      <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        best_reg <= best_next;
        root_reg <= root_next;
        pos_reg  <= pos_next;
        bpos_reg <= bpos_next;
        pre_reg  <= pre_next;
        kth_reg  <= kth_next;
        held_reg <= held_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kth   = kth_reg;
    assign out_held  = held_reg;

    `KLS_ASSERT_SAME(a_size_cap, 1'b1, size_reg <= CW'(kls_pkg::CAPACITY))
    `KLS_ASSERT_SAME(a_write_in_heap, mem_we, CW'(pos_reg) < size_reg)
    `KLS_ASSERT_NEXT(a_grow_one, ctrl.op == kls_pkg::OP_GROW, size_reg == $past(size_reg) + CW'(1))

endmodule

### hw/rtl/kth_largest_stream_tracker.sv
// Top level: k-largest tracker on a min-heap, stream ports and k register.
`timescale 1ns / 1ps
// Flow: after an input transfer a dropped value goes from the check step to finish;
// when the heap grows the value is lifted one level per read, compare and move step;
// a replaced root sinks one level per read, compare and move step; a preload item ends
// at finish with no result; one microcode step per cycle. Items run one at a time; a
// waiting result holds the next item in emit. Reset (rst_n, asynchronous, active low)
// empties the heap, sets k to 1 and clears the result valid flag without a clearing pass.
module kth_largest_stream_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [kls_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] new_value
    input  logic                                s_axis_tuser,  // [0] preload
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kls_pkg::OUT_W-1:0]           m_axis_tdata,  // [31:0] kth_value,
                                                               // [38:32] held_count
    // k register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kls_pkg::CNT_W-1:0]           cfg_data       // [6:0] kept_count
);

    kls_pkg::ctrl_t  ctrl;
    kls_pkg::flags_t flags;

    logic [kls_pkg::DATA_W-1:0] kth_value;
    logic [kls_pkg::CNT_W-1:0]  held_count;

    // The control store drives the datapath one word per step
    kls_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Heap, sift registers and the result register that holds a finished transfer
    kls_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .in_valid  (s_axis_tvalid),
        .in_value  (s_axis_tdata),
        .in_pre    (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kth   (kth_value),
        .out_held  (held_count)
    );

    // Ready only in the idle step; a waiting result holds the next item in the emit step
    assign s_axis_tready = ctrl.in_rdy;

    // Pack the result fields, zero fill up to whole bytes
    assign m_axis_tdata = {
        {(kls_pkg::OUT_W - kls_pkg::DATA_W - kls_pkg::CNT_W){1'b0}},
        held_count,
        kth_value
    };

endmodule
